/* rtl/prx_pkg.sv */
package prx_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned FIELD_W    = 12;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam int unsigned MAX_DIMENSION_DEF = 4096;

  // Register indexes on the configuration channel.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCAN_MODE    = 3'd0,
    REG_KEEP_EQUAL   = 3'd1,
    REG_KEY_RED      = 3'd2,
    REG_KEY_GREEN    = 3'd3,
    REG_KEY_BLUE     = 3'd4,
    REG_IMAGE_WIDTH  = 3'd5,
    REG_IMAGE_HEIGHT = 3'd6
  } cfg_reg_t;

  // Scan modes; the unused code behaves as horizontal runs.
  localparam logic [1:0] SCAN_XRUN = 2'd0;
  localparam logic [1:0] SCAN_YRUN = 2'd1;
  localparam logic [1:0] SCAN_DOT  = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic [1:0]       scan_mode;
    logic             keep_equal;
    logic [PIX_W-1:0] key_red;
    logic [PIX_W-1:0] key_green;
    logic [PIX_W-1:0] key_blue;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } cfg_t;

endpackage

/* rtl/prx_ifs.sv */
interface prx_pixel_if;
  import prx_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_red;
  logic [PIX_W-1:0] pixel_green;
  logic [PIX_W-1:0] pixel_blue;
  modport source (output valid, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface prx_run_if;
  import prx_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] line_index;
  logic [FIELD_W-1:0] run_first;
  logic [FIELD_W-1:0] run_final;
  modport source (output valid, line_index, run_first, run_final, input ready);
  modport sink   (input valid, line_index, run_first, run_final, output ready);
endinterface

interface prx_cfg_if;
  import prx_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/prx_cfg_regs.sv */
module prx_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  prx_cfg_if.sink        cfg_wr,
  output prx_pkg::cfg_t  cfg
);
  import prx_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_wr.ready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      case (cfg_reg_t'(cfg_wr.index))
        REG_SCAN_MODE:    cfg_nxt.scan_mode    = cfg_wr.data[1:0];
        REG_KEEP_EQUAL:   cfg_nxt.keep_equal   = cfg_wr.data[0];
        REG_KEY_RED:      cfg_nxt.key_red      = cfg_wr.data[PIX_W-1:0];
        REG_KEY_GREEN:    cfg_nxt.key_green    = cfg_wr.data[PIX_W-1:0];
        REG_KEY_BLUE:     cfg_nxt.key_blue     = cfg_wr.data[PIX_W-1:0];
        REG_IMAGE_WIDTH:  cfg_nxt.image_width  = cfg_wr.data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_nxt.image_height = cfg_wr.data[DIM_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scan_mode    <= SCAN_XRUN;
      cfg_r.keep_equal   <= 1'b1;
      cfg_r.key_red      <= '0;
      cfg_r.key_green    <= '0;
      cfg_r.key_blue     <= '0;
      cfg_r.image_width  <= WIDTH_RST;
      cfg_r.image_height <= HEIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/prx_in_stage.sv */
module prx_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  prx_pixel_if.sink     in_px,
  input  prx_pkg::cfg_t cfg,
  input  logic          take,
  output logic          s1_valid,
  output logic          s1_match
);
  import prx_pkg::*;

  logic s1_vld_r;
  logic s1_vld_nxt;
  logic match_r;
  logic equal;
  logic in_fire;

  // The key compare is done ahead of the register; only the match bit is kept.
  assign equal = (in_px.pixel_red == cfg.key_red) &&
                 (in_px.pixel_green == cfg.key_green) &&
                 (in_px.pixel_blue == cfg.key_blue);

  assign in_px.ready = !s1_vld_r || take;
  assign in_fire     = in_px.valid && in_px.ready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_fire) begin
      s1_vld_nxt = 1'b1;
    end else if (take) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      match_r <= cfg.keep_equal ? equal : !equal;
    end
  end

  assign s1_valid = s1_vld_r;
  assign s1_match = match_r;

endmodule

/* rtl/prx_run_track.sv */
module prx_run_track #(
  parameter int unsigned MAX_DIMENSION = prx_pkg::MAX_DIMENSION_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  prx_pkg::cfg_t cfg,
  input  logic          s1_valid,
  input  logic          s1_match,
  output logic          take,
  prx_run_if.source     out_run
);
  import prx_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_DIMENSION);
  localparam int unsigned LenW = $clog2(MAX_DIMENSION + 1);

  logic [PosW-1:0] pos_r, pos_nxt;
  logic [PosW-1:0] line_r, line_nxt;
  logic [PosW-1:0] start_r, start_nxt;
  logic            open_r, open_nxt;

  logic               out_vld_r, out_vld_nxt;
  logic [FIELD_W-1:0] out_line_r, out_first_r, out_final_r;
  logic [FIELD_W-1:0] emit_first, emit_final;
  logic               emit;

  logic [DIM_W-1:0] len_raw, cnt_raw;
  logic [LenW-1:0]  line_len, line_count;
  logic [LenW-1:0]  pos_inc, line_inc;
  logic             by_columns, dot_mode, last;

  // A dimension of zero counts as one; one above the limit counts as the limit.
  function automatic logic [LenW-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [LenW-1:0] res;
    if (v == '0) begin
      res = LenW'(1);
    end else if (32'(v) > 32'(MAX_DIMENSION)) begin
      res = LenW'(MAX_DIMENSION);
    end else begin
      res = LenW'(v);
    end
    return res;
  endfunction

  assign by_columns = (cfg.scan_mode == SCAN_YRUN);
  assign dot_mode   = (cfg.scan_mode == SCAN_DOT);
  assign len_raw    = by_columns ? cfg.image_height : cfg.image_width;
  assign cnt_raw    = by_columns ? cfg.image_width : cfg.image_height;
  assign line_len   = clamp_dim(len_raw);
  assign line_count = clamp_dim(cnt_raw);
  assign pos_inc    = LenW'(pos_r) + LenW'(1);
  assign line_inc   = LenW'(line_r) + LenW'(1);
  assign last       = (pos_inc >= line_len);

  assign take = s1_valid && (!out_vld_r || out_run.ready);

  always_comb begin
    emit       = 1'b0;
    emit_first = FIELD_W'(pos_r);
    emit_final = FIELD_W'(pos_r);
    open_nxt   = open_r;
    start_nxt  = start_r;
    pos_nxt    = pos_r;
    line_nxt   = line_r;
    if (take) begin
      if (dot_mode) begin
        open_nxt = 1'b0;
        emit     = s1_match;
      end else if (s1_match) begin
        if (!open_r) begin
          open_nxt  = 1'b1;
          start_nxt = pos_r;
        end
        if (last) begin
          emit       = 1'b1;
          emit_first = open_r ? FIELD_W'(start_r) : FIELD_W'(pos_r);
        end
      end else if (open_r) begin
        emit       = 1'b1;
        open_nxt   = 1'b0;
        emit_first = FIELD_W'(start_r);
        emit_final = FIELD_W'(pos_r - PosW'(1));
      end
      if (last) begin
        pos_nxt  = '0;
        open_nxt = 1'b0;
        line_nxt = (line_inc >= line_count) ? '0 : PosW'(line_inc);
      end else begin
        pos_nxt = PosW'(pos_inc);
      end
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r && !out_run.ready;
    if (take) begin
      out_vld_nxt = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      line_r    <= '0;
      start_r   <= '0;
      open_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      line_r    <= line_nxt;
      start_r   <= start_nxt;
      open_r    <= open_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_line_r  <= FIELD_W'(line_r);
      out_first_r <= emit_first;
      out_final_r <= emit_final;
    end
  end

  assign out_run.valid      = out_vld_r;
  assign out_run.line_index = out_line_r;
  assign out_run.run_first  = out_first_r;
  assign out_run.run_final  = out_final_r;

endmodule

/* rtl/pixel_run_extractor_top.sv */
// Pixel run extractor.
// Pixels enter on in_px in scan order, one per transfer: row by row for
// horizontal runs and dots, column by column for vertical runs. Each transfer
// on out_run carries the line index and the first and last position of one
// run of matching pixels, or one matching pixel in dot mode.
// Registers are written through cfg_wr, which is always ready; writes are
// meant to happen only while no pixel is in flight.
// A pixel accepted on in_px is compared with the key into the input register.
// When the tracker takes it, the run tracker updates its position, line and
// open run and loads the result register. A run is therefore offered on
// out_run once the pixel that ends it has passed the input register. While
// out_run does not stall, throughput is one pixel per cycle.
// When the receiver stalls with a run waiting in the result register, the
// tracker holds; one more pixel waits in the input register and in_px.ready
// drops once that register is full and blocked.
// Reset restores the register defaults (horizontal runs, keep equal, black key,
// 640 by 480), sets position and line to zero, closes any run and empties
// both registers.
module pixel_run_extractor_top #(
  parameter int unsigned MAX_DIMENSION = prx_pkg::MAX_DIMENSION_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  prx_pixel_if.sink  in_px,
  prx_run_if.source  out_run,
  prx_cfg_if.sink    cfg_wr
);
  import prx_pkg::*;

  cfg_t cfg;
  logic s1_valid;
  logic s1_match;
  logic take;

  // Register file; the fields feed both stages directly.
  prx_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  // Input register: holds one pixel reduced to its match bit.
  prx_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_px    (in_px),
    .cfg      (cfg),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_match (s1_match)
  );

  // Run tracker and result register.
  prx_run_track #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_match (s1_match),
    .take     (take),
    .out_run  (out_run)
  );

endmodule
